// File: rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg: shared types, constants and arithmetic helpers
// Widths, register indexes, reset values and the rounding and clamping
// functions used by the PID step datapath.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ERR_W      = SAMPLE_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int GAIN_W     = 20;
  localparam int LIM_W      = 23;
  localparam int DRIVE_W    = 24;
  localparam int INT_W      = 24;
  localparam int CFG_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_SHIFT = 12;
  localparam int PROD_W     = GAIN_W + 1 + DIFF_W;
  localparam int TERM_W     = PROD_W - FRAC_SHIFT;
  localparam int SUM_W      = 28;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_WRAP     = 3'd5;

  localparam logic [GAIN_W-1:0] KP_RESET   = 20'd409600;
  localparam logic [GAIN_W-1:0] KI_RESET   = 20'd102400;
  localparam logic [GAIN_W-1:0] KD_RESET   = 20'd40960;
  localparam logic [LIM_W-1:0]  ILIM_RESET = 23'd159984;
  localparam logic [LIM_W-1:0]  OLIM_RESET = 23'd159984;

  // Item kinds.
  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // 180 and 360 degrees in Q12.4.
  localparam logic signed [ERR_W-1:0] HALF_TURN = 17'sd2880;
  localparam logic signed [ERR_W-1:0] FULL_TURN = 17'sd5760;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(2048);

  typedef struct packed {
    logic [GAIN_W-1:0] kp_gain;
    logic [GAIN_W-1:0] ki_gain;
    logic [GAIN_W-1:0] kd_gain;
    logic [LIM_W-1:0]  integral_limit;
    logic [LIM_W-1:0]  output_limit;
    logic              angle_wrap;
  } psc_cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] prev_err;
    logic signed [INT_W-1:0] integral;
  } psc_state_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      limited;
  } psc_result_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] value;
    logic                    hit;
  } psc_clamp_t;

  // Unsigned Q8.12 gain times a signed Q.4 value, giving Q.16.
  function automatic logic signed [PROD_W-1:0] gain_mult(
    input logic [GAIN_W-1:0]        gain,
    input logic signed [DIFF_W-1:0] x
  );
    logic signed [GAIN_W:0]   g;
    logic signed [PROD_W-1:0] p;
    g = $signed({1'b0, gain});
    p = g * x;
    return p;
  endfunction

  // Back to Q.4, rounding to nearest with ties toward plus infinity.
  function automatic logic signed [TERM_W-1:0] round_term(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] q;
    q = p + ROUND_BIAS;
    q = q >>> FRAC_SHIFT;
    return q[TERM_W-1:0];
  endfunction

  function automatic psc_clamp_t clamp_sym(
    input logic signed [SUM_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    psc_clamp_t              r;
    hi = $signed(SUM_W'(lim));
    lo = -hi;
    if (v > hi) begin
      r.value = hi;
      r.hit   = 1'b1;
    end else if (v < lo) begin
      r.value = lo;
      r.hit   = 1'b1;
    end else begin
      r.value = v;
      r.hit   = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: rtl/psc_cfg.sv
// ----------------------------------------------------------------------------
// psc_cfg: configuration register file
// Holds the gains, the two clamp limits and the angle mode bit. Writes to
// an index outside the register list are dropped.
// ----------------------------------------------------------------------------
module psc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psc_pkg::CFG_W-1:0]      cfg_data,
  output psc_pkg::psc_cfg_t              cfg
);
  import psc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp_gain        <= KP_RESET;
      cfg.ki_gain        <= KI_RESET;
      cfg.kd_gain        <= KD_RESET;
      cfg.integral_limit <= ILIM_RESET;
      cfg.output_limit   <= OLIM_RESET;
      cfg.angle_wrap     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KP_GAIN:        cfg.kp_gain        <= cfg_data[GAIN_W-1:0];
        REG_KI_GAIN:        cfg.ki_gain        <= cfg_data[GAIN_W-1:0];
        REG_KD_GAIN:        cfg.kd_gain        <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[LIM_W-1:0];
        REG_OUTPUT_LIMIT:   cfg.output_limit   <= cfg_data[LIM_W-1:0];
        REG_ANGLE_WRAP:     cfg.angle_wrap     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/psc_datapath.sv
// ----------------------------------------------------------------------------
// psc_datapath: one PID step, or a clear that zeroes drive and state
// Forms the error, applies the optional angle wrap, updates the clamped
// integral and sums the three terms into the clamped drive.
// ----------------------------------------------------------------------------
module psc_datapath (
  input  logic                                kind,
  input  logic signed [psc_pkg::SAMPLE_W-1:0] measure,
  input  logic signed [psc_pkg::SAMPLE_W-1:0] target,
  input  psc_pkg::psc_cfg_t                   cfg,
  input  psc_pkg::psc_state_t                 state,
  output psc_pkg::psc_result_t                res,
  output psc_pkg::psc_state_t                 state_next
);
  import psc_pkg::*;

  logic signed [ERR_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] err_ext;
  logic signed [DIFF_W-1:0] diff;
  logic signed [TERM_W-1:0] kp_term;
  logic signed [TERM_W-1:0] ki_term;
  logic signed [TERM_W-1:0] kd_term;
  logic signed [SUM_W-1:0]  int_pre;
  logic signed [SUM_W-1:0]  sum;
  psc_clamp_t               int_c;
  psc_clamp_t               out_c;

  always_comb begin
    err_raw = {target[SAMPLE_W-1], target} - {measure[SAMPLE_W-1], measure};
    // The wrap is applied once; after losing a full turn the error can no
    // longer fall below minus half a turn.
    if (cfg.angle_wrap && (err_raw > HALF_TURN)) begin
      err = err_raw - FULL_TURN;
    end else if (cfg.angle_wrap && (err_raw < -HALF_TURN)) begin
      err = err_raw + FULL_TURN;
    end else begin
      err = err_raw;
    end

    err_ext = {err[ERR_W-1], err};
    diff    = err_ext - {state.prev_err[ERR_W-1], state.prev_err};

    kp_term = round_term(gain_mult(cfg.kp_gain, err_ext));
    ki_term = round_term(gain_mult(cfg.ki_gain, err_ext));
    kd_term = round_term(gain_mult(cfg.kd_gain, diff));

    int_pre = SUM_W'(state.integral) + SUM_W'(ki_term);
    int_c   = clamp_sym(int_pre, cfg.integral_limit);
    sum     = SUM_W'(kp_term) + int_c.value + SUM_W'(kd_term);
    out_c   = clamp_sym(sum, cfg.output_limit);

    if (kind == KIND_CLEAR) begin
      res.drive           = '0;
      res.limited         = 1'b0;
      state_next.prev_err = '0;
      state_next.integral = '0;
    end else begin
      res.drive           = out_c.value[DRIVE_W-1:0];
      res.limited         = out_c.hit;
      state_next.prev_err = err;
      state_next.integral = int_c.value[INT_W-1:0];
    end
  end

endmodule

// File: rtl/pid_step_with_clamps.sv
// ----------------------------------------------------------------------------
// pid_step_with_clamps: positional PID step with integral and output clamps
// Fixed-point PID controller step with anti-windup clamp and a clear item.
// ----------------------------------------------------------------------------
// The block takes one beat per clock unless it stalls, and returns one
// result beat for each input beat. An accepted input beat is held in the
// input register, which feeds the error, multiply, integral clamp and drive
// clamp pass; the pass lands in the result register when the held beat
// advances. The integral and previous error are updated in that same pass,
// so each step sees the state left by the one before it.
// The input side stalls only when a finished result is held by out_stall.
module pid_step_with_clamps (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic signed [psc_pkg::SAMPLE_W-1:0] measure,
  input  logic signed [psc_pkg::SAMPLE_W-1:0] target,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [psc_pkg::DRIVE_W-1:0]  drive,
  output logic                                limited
);
  import psc_pkg::*;

  psc_cfg_t                  cfg;
  psc_state_t                state;
  psc_state_t                state_next;
  psc_result_t               res;
  logic                      s1_valid;
  logic                      s1_kind;
  logic signed [SAMPLE_W-1:0] s1_measure;
  logic signed [SAMPLE_W-1:0] s1_target;
  logic                      advance;
  logic                      in_take;

  psc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  psc_datapath u_datapath (
    .kind       (s1_kind),
    .measure    (s1_measure),
    .target     (s1_target),
    .cfg        (cfg),
    .state      (state),
    .res        (res),
    .state_next (state_next)
  );

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind    <= kind;
      s1_measure <= measure;
      s1_target  <= target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive   <= res.drive;
      limited <= res.limited;
    end
  end

`ifndef SYNTHESIS
  // A held input beat must not change while it waits for the result register.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_kind) &&
                                $stable(s1_measure) && $stable(s1_target)))
    else $error("held input beat changed");

  a_clear_state: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_kind == KIND_CLEAR)) |=> (state == '0))
    else $error("clear beat did not zero the controller state");

  a_int_range: assert property (@(posedge clk) disable iff (rst)
    state.integral != {1'b1, {(INT_W-1){1'b0}}})
    else $error("integral left the clamp range");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive != {1'b1, {(DRIVE_W-1){1'b0}}}))
    else $error("drive left the clamp range");
`endif

endmodule
